[sv/amqp_dd_pkg.sv]
package amqp_dd_pkg;

  localparam logic [7:0]  EndMark     = 8'hCE;
  localparam logic [31:0] CmDeliver   = 32'h003C003C;
  localparam logic [31:0] CmChanClose = 32'h00140028;
  localparam logic [31:0] CmConnClose = 32'h000A0032;
  localparam logic [31:0] HdrMinLen   = 32'd14;
  localparam logic [7:0]  FtMethod    = 8'd1;
  localparam logic [7:0]  FtHeader    = 8'd2;
  localparam logic [7:0]  FtBody      = 8'd3;

  localparam logic [1:0] KindBody = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindErr  = 2'd2;

  localparam logic [2:0] ErrEnd       = 3'd0;
  localparam logic [2:0] ErrShort     = 3'd1;
  localparam logic [2:0] ErrArgs      = 3'd2;
  localparam logic [2:0] ErrChanClose = 3'd3;
  localparam logic [2:0] ErrConnClose = 3'd4;
  localparam logic [2:0] ErrHeader    = 3'd5;
  localparam logic [2:0] ErrNoHeader  = 3'd6;

  // Front phases, one-hot
  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhPayload = 3'b010,
    PhEnd     = 3'b100
  } phase_e;

  // Result word passed through the queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [63:0] msg_tag;
    logic [63:0] body_size;
    logic [2:0]  error_code;
  } result_t;

endpackage

[sv/amqp_dd_parser.sv]
module amqp_dd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 res_valid_o,
  output amqp_dd_pkg::result_t res_o
);
  import amqp_dd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] idx_q, idx_d;
  logic [7:0]  ftype_q, ftype_d;
  logic [31:0] flen_q, flen_d;
  logic [31:0] cm_q, cm_d;
  logic [7:0]  tlen_q, tlen_d;
  logic [63:0] tshift_q, tshift_d;
  logic [63:0] ctag_q, ctag_d;
  logic [63:0] dsize_q, dsize_d;
  logic [63:0] rcnt_q, rcnt_d;
  logic        mseen_q, mseen_d, hseen_q, hseen_d, halt_q, halt_d;
  logic [32:0] tag_lo, tag_hi, args_min;
  logic        rcnt_lt;
  result_t     r;
  logic        rv;

  assign tag_lo   = 33'd5 + {25'd0, tlen_q};
  assign tag_hi   = tag_lo + 33'd8;
  assign args_min = 33'd13 + {25'd0, tlen_q};
  assign rcnt_lt  = rcnt_q < dsize_q;

  // Classify one byte and update frame state
  always_comb begin
    phase_d = phase_q; idx_d = idx_q; ftype_d = ftype_q; flen_d = flen_q;
    cm_d = cm_q; tlen_d = tlen_q; tshift_d = tshift_q; ctag_d = ctag_q;
    dsize_d = dsize_q; rcnt_d = rcnt_q; mseen_d = mseen_q; hseen_d = hseen_q;
    halt_d = halt_q;
    r = '0;
    rv = 1'b0;
    if (in_valid_i && !halt_q) begin
      case (phase_q)
        PhHeader: begin
          if (idx_q == 32'd0) begin
            ftype_d = rx_byte_i; flen_d = '0; cm_d = '0; tlen_d = '0; tshift_d = '0;
          end else if (idx_q >= 32'd3) begin
            flen_d = {flen_q[23:0], rx_byte_i};
          end
          if (idx_q >= 32'd6) begin
            idx_d = '0;
            phase_d = (flen_d == 32'd0) ? PhEnd : PhPayload;
          end else begin
            idx_d = idx_q + 32'd1;
          end
        end
        PhPayload: begin
          if (ftype_q == FtMethod) begin
            if (idx_q < 32'd4) cm_d = {cm_q[23:0], rx_byte_i};
            else if (idx_q == 32'd4) tlen_d = rx_byte_i;
            else if ({1'b0, idx_q} >= tag_lo && {1'b0, idx_q} < tag_hi)
              tshift_d = {tshift_q[55:0], rx_byte_i};
          end else if (ftype_q == FtHeader) begin
            if (idx_q >= 32'd4 && idx_q < 32'd12) dsize_d = {dsize_q[55:0], rx_byte_i};
          end else if (ftype_q == FtBody) begin
            if (hseen_q && rcnt_lt) begin
              rcnt_d = rcnt_q + 64'd1;
              rv = 1'b1; r.kind = KindBody; r.body_byte = rx_byte_i;
            end
          end
          if (idx_q + 32'd1 >= flen_q || idx_q == 32'hFFFFFFFF) begin
            phase_d = PhEnd; idx_d = '0;
          end else begin
            idx_d = idx_q + 32'd1;
          end
        end
        PhEnd: begin
          phase_d = PhHeader; idx_d = '0;
          if (rx_byte_i != EndMark) begin
            rv = 1'b1; r.kind = KindErr; r.error_code = ErrEnd;
          end else if (ftype_q == FtMethod) begin
            if (flen_q < 32'd4) begin
              rv = 1'b1; r.kind = KindErr; r.error_code = ErrShort;
            end else if (cm_q == CmDeliver) begin
              if ({1'b0, flen_q} < args_min) begin
                rv = 1'b1; r.kind = KindErr; r.error_code = ErrArgs;
              end else begin
                ctag_d = tshift_q; mseen_d = 1'b1;
              end
            end else if (cm_q == CmChanClose) begin
              rv = 1'b1; r.kind = KindErr; r.error_code = ErrChanClose;
            end else if (cm_q == CmConnClose) begin
              rv = 1'b1; r.kind = KindErr; r.error_code = ErrConnClose;
            end
          end else if (ftype_q == FtHeader) begin
            if (!mseen_q || flen_q < HdrMinLen) begin
              rv = 1'b1; r.kind = KindErr; r.error_code = ErrHeader;
            end else if (dsize_q == 64'd0) begin
              rv = 1'b1; r.kind = KindDone; r.msg_tag = ctag_q; r.body_size = 64'd0;
              mseen_d = 1'b0; hseen_d = 1'b0; dsize_d = '0; rcnt_d = '0;
            end else begin
              hseen_d = 1'b1;
            end
          end else if (ftype_q == FtBody) begin
            if (!hseen_q) begin
              rv = 1'b1; r.kind = KindErr; r.error_code = ErrNoHeader;
            end else if (!rcnt_lt) begin
              rv = 1'b1; r.kind = KindDone; r.msg_tag = ctag_q; r.body_size = dsize_q;
              mseen_d = 1'b0; hseen_d = 1'b0; dsize_d = '0; rcnt_d = '0;
            end
          end
          if (rv && r.kind == KindErr) halt_d = 1'b1;
        end
        default: phase_d = PhHeader;
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; idx_q <= '0; ftype_q <= '0; flen_q <= '0; cm_q <= '0;
      tlen_q <= '0; tshift_q <= '0; ctag_q <= '0; dsize_q <= '0; rcnt_q <= '0;
      mseen_q <= 1'b0; hseen_q <= 1'b0; halt_q <= 1'b0;
    end else begin
      phase_q <= phase_d; idx_q <= idx_d; ftype_q <= ftype_d; flen_q <= flen_d;
      cm_q <= cm_d; tlen_q <= tlen_d; tshift_q <= tshift_d; ctag_q <= ctag_d;
      dsize_q <= dsize_d; rcnt_q <= rcnt_d; mseen_q <= mseen_d; hseen_q <= hseen_d;
      halt_q <= halt_d;
    end
  end

  assign res_valid_o = rv;
  assign res_o = r;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt cleared");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> !res_valid_o) else $error("result while halted");
  a_hdr_implies_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hseen_q |-> mseen_q) else $error("header without method");
endmodule

[sv/amqp_dd_queue.sv]
module amqp_dd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  amqp_dd_pkg::result_t wdata_i,
  output logic                 full_o,
  input  logic                 rd_i,
  output logic                 empty_o,
  output amqp_dd_pkg::result_t rdata_o
);
  import amqp_dd_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  result_t        mem_q [Depth];
  logic [Aw-1:0]  wp_q, rp_q;
  logic [Aw:0]    cnt_q;
  logic           do_wr, do_rd;

  assign do_wr = wr_i;
  assign do_rd = rd_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  // Stop input only when every slot holds a word
  assign full_o = (cnt_q == (Aw+1)'(Depth));
  assign rdata_o = mem_q[rp_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (Aw+1)'(Depth)) |-> !(do_wr && !do_rd)) else $error("queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(Depth)) else $error("count out of range");
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !wr_i) |=> empty_o) else $error("empty queue went nonempty");
endmodule

[sv/amqp_delivery_deframer_unit.sv]
// Channel  | Direction | Handshake          | Word
// input    | in        | push / full        | rx_byte_i
// result   | out       | pop / empty        | kind_o, body_byte_o, msg_tag_o,
//          |           |                    | body_size_o, error_code_o
// One byte is taken per cycle while full is low; a result enters the queue in the cycle
// its byte is taken and can be popped from the next cycle on.
// The sustained rate is set by the combinational parser front; the queue decouples pop.
// Reset clears all frame state and empties the queue; no clearing pass.
// full rises when the queue holds QueueDepth words, so stalls on pop reach push.
module amqp_delivery_deframer_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic [63:0] msg_tag_o,
  output logic [63:0] body_size_o,
  output logic [2:0]  error_code_o
);
  import amqp_dd_pkg::*;

  logic    acc, res_v, q_full;
  result_t res, head;

  assign full = q_full;
  assign acc  = push && !q_full;

  amqp_dd_parser u_parser (
    .clk_i, .rst_ni, .in_valid_i(acc), .rx_byte_i,
    .res_valid_o(res_v), .res_o(res)
  );

  amqp_dd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_i(res_v), .wdata_i(res), .full_o(q_full),
    .rd_i(pop), .empty_o(empty), .rdata_o(head)
  );

  assign kind_o         = head.kind;
  assign body_byte_o    = head.body_byte;
  assign msg_tag_o      = head.msg_tag;
  assign body_size_o    = head.body_size;
  assign error_code_o   = head.error_code;
endmodule
